>>> design/response_crc16_frame_checker_assert.svh
// Assertion macros used by the frame checker top level.
`ifndef RESPONSE_CRC16_FRAME_CHECKER_ASSERT_SVH
`define RESPONSE_CRC16_FRAME_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RCFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

>>> design/rcfc_pkg.sv
// Package with the types and constants of the response frame checker.
package rcfc_pkg;

  localparam int unsigned CrcWidth = 16;
  localparam logic [CrcWidth-1:0] CrcPoly = 16'h8005;
  localparam logic [7:0] MinLength = 8'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_MISMATCH   = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0]          frame_length;
    logic [CrcWidth-1:0] computed_crc;
    status_e             check_status;
  } result_t;

endpackage

>>> design/rcfc_crc_byte.sv
// One-byte CRC-16 update, data fed least significant bit first.
module rcfc_crc_byte (
  input  logic [rcfc_pkg::CrcWidth-1:0] crc_i,
  input  logic [7:0]                    data_i,
  output logic [rcfc_pkg::CrcWidth-1:0] crc_o
);

  always_comb begin
    logic [rcfc_pkg::CrcWidth-1:0] c;
    c = crc_i;
    for (int i = 0; i < 8; i++) begin
      if (data_i[i] != c[rcfc_pkg::CrcWidth-1]) begin
        c = {c[rcfc_pkg::CrcWidth-2:0], 1'b0} ^ rcfc_pkg::CrcPoly;
      end else begin
        c = {c[rcfc_pkg::CrcWidth-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

>>> design/response_crc16_frame_checker.sv
// Top level: checks the length and CRC-16 trailer of response frames, one byte a beat.
// A status beat is registered and appears in the cycle after the beat that completes a frame.
// Throughput: one input beat per cycle unless stalled; the byte CRC update sits between the
// input beat and the running CRC register, and the result register is the only output stage.
// Input is stalled only while a finished status beat waits on the output.
// Reset clears the frame state and drops any pending status beat.
`include "response_crc16_frame_checker_assert.svh"

module response_crc16_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: rx_byte[7:0].
  input  logic [7:0]  s_axis_tdata,
  // Fields from bit 0: frame_start[0].
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: check_status[1:0], computed_crc[17:2], frame_length[25:18], zero[31:26].
  output logic [31:0] m_axis_tdata
);

  localparam int unsigned CW = rcfc_pkg::CrcWidth;

  logic          in_frame_q, in_frame_d;
  logic [7:0]    pos_q, pos_d;
  logic [7:0]    len_q, len_d;
  logic [CW-1:0] crc_q, crc_d;
  logic          low_ok_q, low_ok_d;
  logic          out_valid_q, out_valid_d;
  rcfc_pkg::result_t out_q, res;
  logic          res_valid;

  logic          accept;
  logic [7:0]    rx_byte;
  logic          start;
  logic [7:0]    pos_eff, len_eff;
  logic [CW-1:0] crc_eff, crc_fed;
  logic          low_ok_eff;
  logic [8:0]    pos_plus2;

  assign rx_byte       = s_axis_tdata;
  assign start         = s_axis_tuser[0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign pos_eff    = start ? 8'd0 : pos_q;
  assign len_eff    = start ? rx_byte : len_q;
  assign crc_eff    = start ? '0 : crc_q;
  assign low_ok_eff = start ? 1'b0 : low_ok_q;
  assign pos_plus2  = {1'b0, pos_eff} + 9'd2;

  rcfc_crc_byte u_crc (
    .crc_i  (crc_eff),
    .data_i (rx_byte),
    .crc_o  (crc_fed)
  );

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    crc_d      = crc_q;
    low_ok_d   = low_ok_q;
    res_valid  = 1'b0;
    res.check_status = rcfc_pkg::ST_OK;
    res.computed_crc = crc_eff;
    res.frame_length = len_eff;
    if (accept && start && (rx_byte < rcfc_pkg::MinLength)) begin
      in_frame_d = 1'b0;
      pos_d      = 8'd0;
      len_d      = rx_byte;
      crc_d      = '0;
      low_ok_d   = 1'b0;
      res_valid  = 1'b1;
      res.check_status = rcfc_pkg::ST_BAD_LENGTH;
      res.computed_crc = '0;
    end else if (accept && (start || in_frame_q)) begin
      len_d = len_eff;
      if (pos_plus2 < {1'b0, len_eff}) begin
        in_frame_d = 1'b1;
        pos_d      = pos_eff + 8'd1;
        crc_d      = crc_fed;
        low_ok_d   = low_ok_eff;
      end else if (pos_plus2 == {1'b0, len_eff}) begin
        in_frame_d = 1'b1;
        pos_d      = pos_eff + 8'd1;
        crc_d      = crc_eff;
        low_ok_d   = (rx_byte == crc_eff[7:0]);
      end else begin
        in_frame_d = 1'b0;
        pos_d      = 8'd0;
        crc_d      = crc_eff;
        low_ok_d   = 1'b0;
        res_valid  = 1'b1;
        res.check_status = (low_ok_eff && (rx_byte == crc_eff[CW-1:8])) ?
                           rcfc_pkg::ST_OK : rcfc_pkg::ST_MISMATCH;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (!out_valid_q || m_axis_tready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      pos_q       <= 8'd0;
      len_q       <= 8'd0;
      crc_q       <= '0;
      low_ok_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      crc_q       <= crc_d;
      low_ok_q    <= low_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q};

  `RCFC_ASSERT_SAME(a_idle_clear, clk_i, rst_ni, !in_frame_q, (pos_q == 8'd0) && !low_ok_q)
  `RCFC_ASSERT_SAME(a_open_len, clk_i, rst_ni, in_frame_q, len_q >= rcfc_pkg::MinLength)
  `RCFC_ASSERT_SAME(a_stall_blocks, clk_i, rst_ni, out_valid_q && !m_axis_tready,
                    !s_axis_tready)
  `RCFC_ASSERT_SAME(a_bad_len_out, clk_i, rst_ni,
                    out_valid_q && (out_q.check_status == rcfc_pkg::ST_BAD_LENGTH),
                    (out_q.computed_crc == '0) && (out_q.frame_length < rcfc_pkg::MinLength))

endmodule
